FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the ring lookup rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition a implies condition b in the same cycle
`define AST_IMPLY(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error(msg);

// condition a implies condition b in the following cycle
`define AST_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error(msg);

`endif

FILE: hdl/orol_pkg.sv
// ---------------------------------------------------------------------------
// orol_pkg
// types, constants and helpers for the overwriting ring with offset lookup
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package orol_pkg;

  localparam int RING_SLOTS = 16;
  localparam int SLOT_W     = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int LEN_W      = 16;
  localparam int HANDLE_W   = 32;
  localparam int QOFF_W     = 20;
  localparam int HIT_W      = 4;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic                op;
    logic [LEN_W-1:0]    record_length;
    logic [HANDLE_W-1:0] record_handle;
    logic [QOFF_W-1:0]   query_offset;
  } orol_in_t;

  typedef struct packed {
    logic                found;
    logic [HIT_W-1:0]    hit_index;
    logic [HANDLE_W-1:0] hit_handle;
    logic [LEN_W-1:0]    hit_length;
    logic [LEN_W-1:0]    byte_in_record;
  } orol_out_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    length;
  } orol_entry_t;

  typedef struct packed {
    logic        we;
    slot_t       waddr;
    orol_entry_t wdata;
    slot_t       raddr;
  } orol_mem_req_t;

  function automatic slot_t next_slot(input slot_t s);
    if (s == slot_t'(RING_SLOTS - 1)) begin
      return '0;
    end
    return s + slot_t'(1);
  endfunction

endpackage

FILE: hdl/orol_ram.sv
// ---------------------------------------------------------------------------
// orol_ram
// simple dual port ram, one write port, one read port with registered data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module orol_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/orol_ctrl.sv
// ---------------------------------------------------------------------------
// orol_ctrl
// ring indices, slot valid bits and the find walk over the record memory
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module orol_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  orol_pkg::orol_in_t     in_data,
  output orol_pkg::orol_mem_req_t mem_req,
  input  orol_pkg::orol_entry_t  mem_rdata,
  output logic                   res_valid,
  input  logic                   res_take,
  output orol_pkg::orol_out_t    res_data
);

  import orol_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                  state_r, state_nxt;
  slot_t                 wr_idx_r, wr_idx_nxt;
  slot_t                 rd_idx_r, rd_idx_nxt;
  logic                  full_r, full_nxt;
  logic [RING_SLOTS-1:0] valid_r;
  slot_t                 slot_r, slot_nxt;
  logic [QOFF_W-1:0]     remain_r, remain_nxt;
  logic                  vld_q_r;
  logic                  res_pend_r, res_pend_nxt;
  orol_out_t             res_r, res_nxt;

  logic                  accept;
  logic                  do_add;
  logic                  do_find;
  logic [LEN_W-1:0]      cur_len;
  logic [QOFF_W-1:0]     cur_len_ext;
  logic                  hit;
  slot_t                 walk_next;
  logic                  walk_last;
  slot_t                 add_wr;
  slot_t                 add_rd;

  assign in_stall = (state_r != ST_IDLE) || res_pend_r;
  assign accept   = in_valid && !in_stall;
  assign do_add   = accept && (in_data.op == OP_ADD);
  assign do_find  = accept && (in_data.op == OP_FIND);

  // slots never written read as zero length
  assign cur_len     = vld_q_r ? mem_rdata.length : '0;
  assign cur_len_ext = {{(QOFF_W - LEN_W){1'b0}}, cur_len};
  assign hit         = remain_r < cur_len_ext;
  assign walk_next   = next_slot(slot_r);
  assign walk_last   = walk_next == wr_idx_r;

  assign add_rd = full_r ? next_slot(rd_idx_r) : rd_idx_r;
  assign add_wr = next_slot(wr_idx_r);

  always_comb begin
    mem_req.we            = do_add;
    mem_req.waddr         = wr_idx_r;
    mem_req.wdata.handle  = in_data.record_handle;
    mem_req.wdata.length  = in_data.record_length;
    // keep the read one slot ahead of the compare during a walk
    mem_req.raddr         = (state_r == ST_WALK) ? walk_next : rd_idx_r;
  end

  always_comb begin
    state_nxt    = state_r;
    wr_idx_nxt   = wr_idx_r;
    rd_idx_nxt   = rd_idx_r;
    full_nxt     = full_r;
    slot_nxt     = slot_r;
    remain_nxt   = remain_r;
    res_pend_nxt = res_pend_r;
    res_nxt      = res_r;

    if (res_take) begin
      res_pend_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (do_add) begin
          wr_idx_nxt = add_wr;
          rd_idx_nxt = add_rd;
          if (add_wr == add_rd) begin
            full_nxt = 1'b1;
          end
        end else if (do_find) begin
          state_nxt  = ST_WALK;
          slot_nxt   = rd_idx_r;
          remain_nxt = in_data.query_offset;
        end
      end
      ST_WALK: begin
        if (hit) begin
          res_nxt.found          = 1'b1;
          res_nxt.hit_index      = HIT_W'(slot_r);
          res_nxt.hit_handle     = mem_rdata.handle;
          res_nxt.hit_length     = cur_len;
          res_nxt.byte_in_record = remain_r[LEN_W-1:0];
          res_pend_nxt           = 1'b1;
          state_nxt              = ST_IDLE;
        end else if (walk_last) begin
          res_nxt      = '0;
          res_pend_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          slot_nxt   = walk_next;
          remain_nxt = remain_r - cur_len_ext;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      wr_idx_r   <= '0;
      rd_idx_r   <= '0;
      full_r     <= 1'b0;
      valid_r    <= '0;
      res_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wr_idx_r   <= wr_idx_nxt;
      rd_idx_r   <= rd_idx_nxt;
      full_r     <= full_nxt;
      res_pend_r <= res_pend_nxt;
      if (do_add) begin
        valid_r[wr_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r   <= slot_nxt;
    remain_r <= remain_nxt;
    res_r    <= res_nxt;
    vld_q_r  <= valid_r[mem_req.raddr];
  end

  assign res_valid = res_pend_r;
  assign res_data  = res_r;

  `AST_IMPLY(a_walk_no_pending, clk, rst_n, state_r == ST_WALK, !res_pend_r,
             "walk running while a result is still pending")
  `AST_IMPLY(a_full_meets, clk, rst_n, full_r, wr_idx_r == rd_idx_r,
             "ring marked full while indices differ")
  `AST_IMPLY(a_no_write_in_walk, clk, rst_n, mem_req.we, state_r == ST_IDLE,
             "record memory written during a walk")

endmodule

FILE: hdl/overwrite_ring_offset_lookup.sv
// ---------------------------------------------------------------------------
// overwrite_ring_offset_lookup
// ring of length/handle records that overwrites the oldest, with a lookup
// that maps a byte offset in the joined records to its record
//
// in_* channel: one beat per item. op add stores a record and gives no
//   result; op find gives exactly one result beat on out_*.
// an add writes its record in the cycle it is accepted. a find walks the ring
//   one slot per cycle through the record memory (one read per cycle,
//   registered read data); the time from accept to result ready is set by the
//   number of slots visited before the hit or the end of the stored data.
// one item is worked on at a time; in_stall is high during a walk and while
//   a finished result still waits in the internal result register.
// results go out through an output register, so a new item is taken while
//   the previous result is held by a high out_stall.
// reset (rst_n low, synchronous) empties the ring: all lengths read as zero
//   and both indices return to slot zero; no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module overwrite_ring_offset_lookup (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  orol_pkg::orol_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output orol_pkg::orol_out_t out_data
);

  import orol_pkg::*;

  orol_mem_req_t mem_req;
  orol_entry_t   mem_rdata;
  logic          res_valid;
  logic          res_take;
  orol_out_t     res_data;
  logic          out_valid_r, out_valid_nxt;
  orol_out_t     out_data_r;

  orol_ram #(
    .DEPTH (RING_SLOTS),
    .WIDTH ($bits(orol_entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  orol_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_data  (res_data)
  );

  // output register loads a pending result whenever it is empty or its beat leaves this cycle
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `AST_NEXT(a_take_loads, clk, rst_n, res_take, out_valid_r,
            "result taken but output register empty")

endmodule
